FILE: src/session_cache_oldest_replace_macros.svh
// assertion macros for the session cache checker
`ifndef SESSION_CACHE_OLDEST_REPLACE_MACROS_SVH
`define SESSION_CACHE_OLDEST_REPLACE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SCO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sco_pkg.sv
package sco_pkg;

  localparam int ENTRIES      = 8;
  localparam int SLOT_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_WORDS    = 4;
  localparam int SECRET_WORDS = 6;
  localparam int KEY_MEM      = ENTRIES * KEY_WORDS;
  localparam int SEC_MEM      = ENTRIES * SECRET_WORDS;
  localparam int KEY_AW       = $clog2(KEY_MEM);
  localparam int SEC_AW       = $clog2(SEC_MEM);
  localparam logic [5:0]  KEY_BYTES_MAX = 6'd32;
  localparam logic [31:0] NO_TIME       = 32'hFFFF_FFFF;
  localparam logic [31:0] EXPIRY_RESET  = 32'd86400;

  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_FIND  = 2'd1;
  localparam logic [1:0] ACT_PRUNE = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STORE_SCAN,
    S_STORE_WRITE,
    S_FIND_LEN,
    S_FIND_KEY,
    S_FIND_WAIT,
    S_FIND_CHECK,
    S_FIND_OUT,
    S_PRUNE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              latch_req;
    logic              clr_scan;
    logic              scan_step;
    logic              store_step;
    logic              write_step;
    logic              key_word_clr;
    logic              key_word_step;
    logic              set_valid;
    logic              clr_valid;
    logic              prune_step;
    logic              sec_step;
    logic              sec_clr;
    logic              emit;
    logic              emit_secret;
    logic              emit_last;
    logic [1:0]        emit_status;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       len_ok;
    logic       scan_end;
    logic       slot_valid;
    logic       store_found;
    logic       write_end;
    logic       len_match;
    logic       word_match;
    logic       key_word_end;
    logic       slot_expired;
    logic       time_ok;
    logic       sec_end;
  } stat_t;

  function automatic logic [63:0] key_mask(input logic [5:0] len, input logic [1:0] w);
    logic [6:0] base;
    logic [6:0] n;
    logic [63:0] m;
    base = {2'b00, w, 3'b000};
    m = '0;
    if ({1'b0, len} > base) begin
      n = {1'b0, len} - base;
      if (n >= 7'd8) m = '1;
      else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> (n * 8));
    end
    return m;
  endfunction

endpackage

FILE: src/session_cache_oldest_replace.sv
// channel   signals                                          direction
// request   start, busy (out), action, key_len, word_sel,    in
//           data_word, time_now, time_ok, req_last
// result    result_valid, status, secret_word, secret_index,  out
//           run_last
// config    cfg_we, cfg_data                                 in
//
// beats are taken on start in idle; a final beat holds busy for its whole operation
// a reject ends at dispatch, prune tests every slot, store scans slots up to
// the first free one, then writes ten words, or nothing when no slot is chosen
// find: per slot a length test, key word compares, an expiry check; 6 result beats
// each result beat is registered from its controller cycle and cannot be stalled
// rst is synchronous, clears valid bits, and resets expiry and the controller
module session_cache_oldest_replace import sco_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [5:0]  key_len,
  input  logic [3:0]  word_sel,
  input  logic [63:0] data_word,
  input  logic [31:0] time_now,
  input  logic        time_ok,
  input  logic        req_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [63:0] secret_word,
  output logic [2:0]  secret_index,
  output logic        run_last
);

  ctrl_t ct;
  stat_t st;

  sco_ctrl u_ctrl (
    .clk, .rst, .start, .req_last, .st, .ct, .busy
  );

  sco_datapath u_dp (
    .clk, .rst, .ct, .action, .key_len, .word_sel, .data_word, .time_now,
    .time_ok, .cfg_we, .cfg_data, .st, .result_valid, .status, .secret_word,
    .secret_index, .run_last
  );

endmodule

FILE: src/sco_ctrl.sv
module sco_ctrl import sco_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  req_last,
  input  stat_t st,
  output ctrl_t ct,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ct = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ct.latch_req = 1'b1;
          ct.clr_scan = 1'b1;
          if (req_last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        // dispatch on the latched request
        ct.clr_scan = 1'b1;
        priority if (st.action == ACT_PRUNE) state_next = S_PRUNE;
        else if (st.action == ACT_RSVD || !st.len_ok) begin
          ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_REJECT;
          state_next = S_IDLE;
        end else if (st.action == ACT_STORE) state_next = S_STORE_SCAN;
        else state_next = S_FIND_LEN;
      end
      S_PRUNE: begin
        ct.prune_step = 1'b1;
        ct.scan_step = 1'b1;
        if (st.scan_end) begin
          ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_STORE_SCAN: begin
        ct.store_step = 1'b1;
        ct.scan_step = 1'b1;
        if (!st.slot_valid || st.scan_end) state_next = S_STORE_WRITE;
      end
      S_STORE_WRITE: begin
        if (!st.store_found) begin
          ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_NOSLOT;
          state_next = S_IDLE;
        end else begin
          ct.write_step = 1'b1;
          if (st.write_end) begin
            ct.set_valid = 1'b1;
            ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_OK;
            state_next = S_IDLE;
          end
        end
      end
      S_FIND_LEN: begin
        ct.key_word_clr = 1'b1;
        ct.sec_clr = 1'b1;
        if (st.slot_valid && st.len_match) state_next = S_FIND_KEY;
        else if (st.scan_end) begin
          ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_REJECT;
          state_next = S_IDLE;
        end else ct.scan_step = 1'b1;
      end
      S_FIND_KEY: begin
        ct.key_word_step = 1'b1;
        state_next = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        // registered key word read compares here
        if (!st.word_match) begin
          if (st.scan_end) begin
            ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_REJECT;
            state_next = S_IDLE;
          end else begin
            ct.scan_step = 1'b1;
            state_next = S_FIND_LEN;
          end
        end else if (st.key_word_end) state_next = S_FIND_CHECK;
        else state_next = S_FIND_KEY;
      end
      S_FIND_CHECK: begin
        if (st.time_ok && st.slot_expired) begin
          ct.clr_valid = 1'b1;
          if (st.scan_end) begin
            ct.emit = 1'b1; ct.emit_last = 1'b1; ct.emit_status = ST_REJECT;
            state_next = S_IDLE;
          end else begin
            ct.scan_step = 1'b1;
            state_next = S_FIND_LEN;
          end
        end else begin
          // fetch secret word 0 ahead of the first beat
          ct.sec_step = 1'b1;
          state_next = S_FIND_OUT;
        end
      end
      S_FIND_OUT: begin
        ct.emit = 1'b1;
        ct.emit_secret = 1'b1;
        ct.emit_status = ST_OK;
        ct.sec_step = 1'b1;
        if (st.sec_end) begin
          ct.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/sco_datapath.sv
module sco_datapath import sco_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ct,
  input  logic [1:0]  action,
  input  logic [5:0]  key_len,
  input  logic [3:0]  word_sel,
  input  logic [63:0] data_word,
  input  logic [31:0] time_now,
  input  logic        time_ok,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output stat_t       st,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [63:0] secret_word,
  output logic [2:0]  secret_index,
  output logic        run_last
);

  logic [63:0] key_buf [KEY_WORDS];
  logic [63:0] sec_buf [SECRET_WORDS];
  logic [63:0] key_mem [KEY_MEM];
  logic [63:0] sec_mem [SEC_MEM];
  logic [5:0]  len_mem [ENTRIES];
  logic [31:0] created [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [31:0] expiry;
  logic [1:0]  req_action;
  logic [5:0]  req_len;
  logic [31:0] req_time;
  logic        req_time_ok;
  logic [SLOT_W-1:0] scan, slot;
  logic [31:0] oldest;
  logic        found;
  logic [3:0]  wcnt;
  logic [1:0]  kw;
  logic [63:0] key_rd;
  logic [1:0]  kw_rd;
  logic [2:0]  sidx;
  logic [63:0] sec_rd;
  logic [2:0]  sidx_rd;
  logic        expired_scan;

  assign expired_scan = (req_time - created[scan]) > expiry;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= EXPIRY_RESET;
      valid <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) expiry <= cfg_data;
      if (ct.prune_step && valid[scan] && expired_scan) valid[scan] <= 1'b0;
      if (ct.clr_valid) valid[scan] <= 1'b0;
      if (ct.set_valid) valid[slot] <= 1'b1;
      result_valid <= ct.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ct.latch_req) begin
      req_action <= action;
      req_len <= key_len;
      req_time <= time_now;
      req_time_ok <= time_ok;
      if (word_sel < 4'(KEY_WORDS)) key_buf[word_sel[1:0]] <= data_word;
      else if (word_sel < 4'(KEY_WORDS + SECRET_WORDS))
        sec_buf[3'(word_sel - 4'(KEY_WORDS))] <= data_word;
    end
    if (ct.clr_scan) begin
      scan <= '0;
      found <= 1'b0;
      oldest <= NO_TIME;
      slot <= '0;
      wcnt <= '0;
    end else if (ct.scan_step && !st.scan_end) scan <= scan + 1'b1;
    if (ct.store_step) begin
      // first free slot wins, else strictly oldest time
      if (!valid[scan]) begin
        slot <= scan; found <= 1'b1;
      end else if (created[scan] < oldest) begin
        oldest <= created[scan]; slot <= scan; found <= 1'b1;
      end
    end
    if (ct.write_step) begin
      // key words 0..3 then secret words 0..5
      if (wcnt < 4'(KEY_WORDS))
        key_mem[KEY_AW'({slot, 2'b00}) + KEY_AW'(wcnt)] <= key_buf[wcnt[1:0]];
      else
        sec_mem[SEC_AW'(slot) * SEC_AW'(SECRET_WORDS) + SEC_AW'(wcnt - 4'(KEY_WORDS))]
          <= sec_buf[3'(wcnt - 4'(KEY_WORDS))];
      wcnt <= wcnt + 4'd1;
      if (wcnt == 4'd0) begin
        len_mem[slot] <= req_len;
        created[slot] <= req_time;
      end
    end
    if (ct.key_word_clr) kw <= '0;
    else if (ct.key_word_step) kw <= kw + 2'd1;
    key_rd <= key_mem[KEY_AW'({scan, 2'b00}) + KEY_AW'(kw)];
    kw_rd <= kw;
    if (ct.sec_clr) sidx <= '0;
    else if (ct.sec_step) sidx <= sidx + 3'd1;
    sec_rd <= sec_mem[SEC_AW'(scan) * SEC_AW'(SECRET_WORDS) + SEC_AW'(sidx)];
    sidx_rd <= sidx;
    status <= ct.emit_status;
    run_last <= ct.emit_last;
    secret_word <= ct.emit_secret ? sec_rd : 64'd0;
    secret_index <= ct.emit_secret ? sidx_rd : 3'd0;
  end

  always_comb begin
    st.action = req_action;
    st.len_ok = (req_len != 6'd0) && (req_len <= KEY_BYTES_MAX);
    st.scan_end = (scan == SLOT_W'(ENTRIES - 1));
    st.slot_valid = valid[scan];
    st.store_found = found;
    st.write_end = (wcnt == 4'(KEY_WORDS + SECRET_WORDS - 1));
    st.len_match = (len_mem[scan] == req_len);
    st.word_match = ((key_rd ^ key_buf[kw_rd]) & key_mask(req_len, kw_rd)) == 64'd0;
    st.key_word_end = (kw_rd == 2'(KEY_WORDS - 1));
    st.slot_expired = expired_scan;
    st.time_ok = req_time_ok;
    st.sec_end = (sidx_rd == 3'(SECRET_WORDS - 1));
  end

endmodule

FILE: src/sco_checker.sv
`include "session_cache_oldest_replace_macros.svh"

module sco_checker import sco_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        req_last,
  input logic        result_valid,
  input logic [1:0]  status,
  input logic [63:0] secret_word,
  input logic [2:0]  secret_index,
  input logic        run_last
);

  `SCO_ASSERT_NEXT(a_last_goes_busy, start && !busy && req_last, busy,
    "final beat did not start an operation")
  `SCO_ASSERT_IMP(a_fail_no_data, result_valid && status != ST_OK,
    secret_word == 64'd0 && secret_index == 3'd0 && run_last, "bad failure beat")
  `SCO_ASSERT_NEXT(a_secret_run, result_valid && !run_last,
    result_valid && secret_index == $past(secret_index) + 3'd1,
    "secret run broken")
  `SCO_ASSERT_NEXT(a_idle_after_last, result_valid && run_last, !result_valid,
    "beat after final result")

endmodule

bind session_cache_oldest_replace sco_checker u_sco_checker (
  .clk, .rst, .start, .busy, .req_last, .result_valid, .status, .secret_word,
  .secret_index, .run_last
);
